// ===== hw/rtl/rmfp_pkg.sv =====
// Shared types and constants for the rotated monochrome frame store plotter.
package rmfp_pkg;

   localparam int         BITS_PER_BYTE = 8;
   localparam int         BIT_IDX_W     = $clog2(BITS_PER_BYTE);
   localparam logic [7:0] BIT_MSB       = 8'h80;
   localparam logic [7:0] COLOR_BLACK   = 8'd1;

   typedef enum logic [1:0] {
      OP_PLOT  = 2'd0,
      OP_CLEAR = 2'd1,
      OP_READ  = 2'd2,
      OP_NOP   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ROT_0   = 2'd0,
      ROT_90  = 2'd1,
      ROT_180 = 2'd2,
      ROT_270 = 2'd3
   } rot_type;

   typedef enum logic [2:0] {
      REG_ROTATION    = 3'd0,
      REG_VIEW_WIDTH  = 3'd1,
      REG_VIEW_HEIGHT = 3'd2,
      REG_ROW_BYTES   = 3'd3,
      REG_ROW_COUNT   = 3'd4
   } reg_index_type;

   typedef struct packed {
      rot_type     rotation;
      logic [9:0]  view_width;
      logic [9:0]  view_height;
      logic [6:0]  row_bytes;
      logic [9:0]  row_count;
   } cfg_type;

   typedef struct packed {
      logic                 out_of_range;
      logic [6:0]           col;
      logic [9:0]           row;
      logic [BIT_IDX_W-1:0] bit_idx;
   } plot_target_type;

endpackage

// ===== hw/rtl/rotated_mono_framebuffer_plotter.sv =====
// Rotated monochrome frame store plotter: top level with sequencer and result register.
//
// This block owns a one-bit-per-pixel frame store of MAX_ROW_BYTES * MAX_ROWS bytes,
// most significant bit leftmost, held in a single synchronous memory. Each request
// beat carries one operation. A plot maps (coord_x, coord_y) through the configured
// rotation to a store column and row, then reads, modifies and writes back the byte
// that holds the pixel: a color value of one clears the bit, any other value sets it.
// A plot that lands outside the configured geometry, or whose mirrored coordinate
// goes negative, leaves the store alone and returns out_of_range. A clear writes the
// fill byte (color_value) over row_bytes * row_count bytes, one byte per cycle. A read
// returns one stored byte, or out_of_range when the address lies beyond the geometry.
// Every request beat produces exactly one response beat. The block works on one
// request at a time, and the memory port sets the pace: a plot passes through accept,
// address and read, then modify and write; a read, a rejected plot and the unused
// operation code through accept, then response; a clear through accept, the byte sweep
// and response. A finished response sits in an output register, so the block returns to
// accepting requests while the consumer stalls; it only holds a completed response
// back when the previous one is still waiting there. The store has no reset and no
// clearing pass: its contents are unknown until plotted or cleared, so issue a clear
// before the first plot or read. Configuration registers (rotation, view_width,
// view_height, row_bytes, row_count at byte offsets 0, 4, 8, 12, 16) may be written
// only while no request is in flight.
module rotated_mono_framebuffer_plotter
   import rmfp_pkg::*;
#(
   parameter int MAX_ROW_BYTES = 64,
   parameter int MAX_ROWS      = 512
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_operation,
   input  logic [8:0]  req_coord_x,
   input  logic [8:0]  req_coord_y,
   input  logic [7:0]  req_color_value,
   input  logic [14:0] req_read_address,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_read_data,
   output logic        rsp_out_of_range,

   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int DEPTH  = MAX_ROW_BYTES * MAX_ROWS;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_LOOKUP = 5'b00010,
      ST_UPDATE = 5'b00100,
      ST_SWEEP  = 5'b01000,
      ST_POST   = 5'b10000
   } state_type;

   cfg_type         cfg;
   plot_target_type target;
   logic [6:0]      eff_row_bytes;
   logic [9:0]      eff_row_count;
   logic [16:0]     extent;
   logic [16:0]     plot_addr;
   logic            req_accept;
   logic            out_free;
   logic            read_oor;
   logic [7:0]      bit_mask;

   // Memory port controls.
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [7:0]        rd_data;
   logic              wr_en;
   logic [7:0]        wr_data;

   // Sequencer and work registers.
   state_type            state_ff,     state_in;
   logic                 is_plot_ff,   is_plot_in;
   logic                 black_ff,     black_in;
   logic [7:0]           fill_ff,      fill_in;
   logic [6:0]           col_ff,       col_in;
   logic [9:0]           row_ff,       row_in;
   logic [BIT_IDX_W-1:0] bit_ff,       bit_in;
   logic [ADDR_W-1:0]    addr_ff,      addr_in;
   logic                 oor_ff,       oor_in;
   logic [CNT_W-1:0]     sweep_end_ff, sweep_end_in;

   // Response register.
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_data_ff,  rsp_data_in;
   logic       rsp_oor_ff,   rsp_oor_in;

   rmfp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // The geometry registers may exceed what the store was built for; clamp them.
   assign eff_row_bytes = (32'(cfg.row_bytes) > 32'(MAX_ROW_BYTES)) ?
                          7'(MAX_ROW_BYTES) : cfg.row_bytes;
   assign eff_row_count = (32'(cfg.row_count) > 32'(MAX_ROWS)) ?
                          10'(MAX_ROWS) : cfg.row_count;

   // Number of bytes in use; bounds both reads and the clear sweep.
   assign extent = 17'(eff_row_bytes) * 17'(eff_row_count);

   rmfp_map u_map (
      .cfg           (cfg),
      .eff_row_bytes (eff_row_bytes),
      .eff_row_count (eff_row_count),
      .coord_x       (req_coord_x),
      .coord_y       (req_coord_y),
      .target        (target)
   );

   rmfp_store #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (addr_ff),
      .wr_data (wr_data)
   );

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid & ~req_stall;
   assign out_free   = ~rsp_valid_ff | ~rsp_stall;
   assign read_oor   = (17'(req_read_address) >= extent);

   // The byte address of a plot is computed in the cycle after accept, from registered
   // column and row, so the multiply does not stack on top of the rotation logic.
   assign plot_addr = 17'(row_ff) * 17'(eff_row_bytes) + 17'(col_ff);
   assign bit_mask  = BIT_MSB >> bit_ff;

   always_comb begin
      state_in     = state_ff;
      is_plot_in   = is_plot_ff;
      black_in     = black_ff;
      fill_in      = fill_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      bit_in       = bit_ff;
      addr_in      = addr_ff;
      oor_in       = oor_ff;
      sweep_end_in = sweep_end_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_data_in  = rsp_data_ff;
      rsp_oor_in   = rsp_oor_ff;
      rd_en        = 1'b0;
      rd_addr      = ADDR_W'(req_read_address);
      wr_en        = 1'b0;
      wr_data      = fill_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               is_plot_in = 1'b0;
               oor_in     = 1'b0;
               unique case (op_type'(req_operation))
                  OP_PLOT: begin
                     is_plot_in = 1'b1;
                     black_in   = (req_color_value == COLOR_BLACK);
                     col_in     = target.col;
                     row_in     = target.row;
                     bit_in     = target.bit_idx;
                     oor_in     = target.out_of_range;
                     state_in   = target.out_of_range ? ST_POST : ST_LOOKUP;
                  end
                  OP_CLEAR: begin
                     fill_in      = req_color_value;
                     addr_in      = '0;
                     sweep_end_in = CNT_W'(extent);
                     state_in     = (extent == 17'd0) ? ST_POST : ST_SWEEP;
                  end
                  OP_READ: begin
                     // An in-range read goes to the memory right away.
                     oor_in = read_oor;
                     rd_en  = ~read_oor;
                     state_in = read_oor ? ST_POST : ST_UPDATE;
                  end
                  OP_NOP: begin
                     state_in = ST_POST;
                  end
                  default: begin
                     state_in = ST_POST;
                  end
               endcase
            end
         end

         ST_LOOKUP: begin
            rd_en    = 1'b1;
            rd_addr  = ADDR_W'(plot_addr);
            addr_in  = ADDR_W'(plot_addr);
            state_in = ST_UPDATE;
         end

         ST_UPDATE: begin
            // The read data register holds until the next read, so waiting here is safe.
            wr_data = black_ff ? (rd_data & ~bit_mask) : (rd_data | bit_mask);
            if (out_free) begin
               wr_en        = is_plot_ff;
               rsp_valid_in = 1'b1;
               rsp_data_in  = is_plot_ff ? 8'd0 : rd_data;
               rsp_oor_in   = 1'b0;
               state_in     = ST_IDLE;
            end
         end

         ST_SWEEP: begin
            wr_en   = 1'b1;
            wr_data = fill_ff;
            addr_in = addr_ff + ADDR_W'(1);
            if ((CNT_W'(addr_ff) + CNT_W'(1)) == sweep_end_ff) begin
               state_in = ST_POST;
            end
         end

         ST_POST: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = 8'd0;
               rsp_oor_in   = oor_ff;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      is_plot_ff   <= is_plot_in;
      black_ff     <= black_in;
      fill_ff      <= fill_in;
      col_ff       <= col_in;
      row_ff       <= row_in;
      bit_ff       <= bit_in;
      addr_ff      <= addr_in;
      oor_ff       <= oor_in;
      sweep_end_ff <= sweep_end_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_oor_ff   <= rsp_oor_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_read_data    = rsp_data_ff;
   assign rsp_out_of_range = rsp_oor_ff;

endmodule

// ===== hw/rtl/rmfp_csr.sv =====
// Configuration register file with an APB-style access port.
module rmfp_csr
   import rmfp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   output cfg_type     cfg
);

   rot_type       rotation_ff,    rotation_in;
   logic [9:0]    view_width_ff,  view_width_in;
   logic [9:0]    view_height_ff, view_height_in;
   logic [6:0]    row_bytes_ff,   row_bytes_in;
   logic [9:0]    row_count_ff,   row_count_in;
   logic          write_hit;
   reg_index_type reg_index;

   assign csr_pready = 1'b1;
   assign write_hit  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign reg_index  = reg_index_type'(csr_paddr[4:2]);

   always_comb begin
      rotation_in    = rotation_ff;
      view_width_in  = view_width_ff;
      view_height_in = view_height_ff;
      row_bytes_in   = row_bytes_ff;
      row_count_in   = row_count_ff;
      if (write_hit) begin
         unique case (reg_index)
            REG_ROTATION:    rotation_in    = rot_type'(csr_pwdata[1:0]);
            REG_VIEW_WIDTH:  view_width_in  = csr_pwdata[9:0];
            REG_VIEW_HEIGHT: view_height_in = csr_pwdata[9:0];
            REG_ROW_BYTES:   row_bytes_in   = csr_pwdata[6:0];
            REG_ROW_COUNT:   row_count_in   = csr_pwdata[9:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rotation_ff    <= ROT_0;
         view_width_ff  <= 10'd512;
         view_height_ff <= 10'd512;
         row_bytes_ff   <= 7'd64;
         row_count_ff   <= 10'd512;
      end else begin
         rotation_ff    <= rotation_in;
         view_width_ff  <= view_width_in;
         view_height_ff <= view_height_in;
         row_bytes_ff   <= row_bytes_in;
         row_count_ff   <= row_count_in;
      end
   end

   always_comb begin
      unique case (reg_index)
         REG_ROTATION:    csr_prdata = {30'd0, rotation_ff};
         REG_VIEW_WIDTH:  csr_prdata = {22'd0, view_width_ff};
         REG_VIEW_HEIGHT: csr_prdata = {22'd0, view_height_ff};
         REG_ROW_BYTES:   csr_prdata = {25'd0, row_bytes_ff};
         REG_ROW_COUNT:   csr_prdata = {22'd0, row_count_ff};
         default:         csr_prdata = 32'd0;
      endcase
   end

   assign cfg.rotation    = rotation_ff;
   assign cfg.view_width  = view_width_ff;
   assign cfg.view_height = view_height_ff;
   assign cfg.row_bytes   = row_bytes_ff;
   assign cfg.row_count   = row_count_ff;

endmodule

// ===== hw/rtl/rmfp_map.sv =====
// Rotation of a logical pixel coordinate to a store column, row and bit.
module rmfp_map
   import rmfp_pkg::*;
(
   input  cfg_type         cfg,
   input  logic [6:0]      eff_row_bytes,
   input  logic [9:0]      eff_row_count,
   input  logic [8:0]      coord_x,
   input  logic [8:0]      coord_y,
   output plot_target_type target
);

   // Twelve bits hold every mirrored value, from -512 up to 1022, in two's complement.
   logic [11:0] x_ext, y_ext, w_ext, h_ext;
   logic [11:0] w_minus_x, w_minus_y, h_minus_x, h_minus_y;
   logic [11:0] col_pos, row_pos;
   logic        wrapped;

   assign x_ext = {3'd0, coord_x};
   assign y_ext = {3'd0, coord_y};
   assign w_ext = {2'd0, cfg.view_width};
   assign h_ext = {2'd0, cfg.view_height};

   assign w_minus_x = w_ext - x_ext - 12'd1;
   assign w_minus_y = w_ext - y_ext - 12'd1;
   assign h_minus_x = h_ext - x_ext - 12'd1;
   assign h_minus_y = h_ext - y_ext - 12'd1;

   always_comb begin
      case (cfg.rotation)
         ROT_0: begin
            col_pos = y_ext;
            row_pos = x_ext;
         end
         ROT_90: begin
            col_pos = x_ext;
            row_pos = h_minus_y;
         end
         ROT_180: begin
            col_pos = w_minus_y;
            row_pos = h_minus_x;
         end
         ROT_270: begin
            col_pos = w_minus_x;
            row_pos = y_ext;
         end
         default: begin
            col_pos = y_ext;
            row_pos = x_ext;
         end
      endcase
   end

   assign wrapped        = col_pos[11] | row_pos[11];
   assign target.col     = col_pos[9:BIT_IDX_W];
   assign target.row     = row_pos[9:0];
   assign target.bit_idx = col_pos[BIT_IDX_W-1:0];
   assign target.out_of_range = wrapped
                              | (target.col >= eff_row_bytes)
                              | (target.row >= eff_row_count);

endmodule

// ===== hw/rtl/rmfp_store.sv =====
// Byte-wide frame store with one write port and one registered read port.
module rmfp_store #(
   parameter int DEPTH  = 32768,
   parameter int ADDR_W = 15
) (
   input  logic              clock,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [7:0]        rd_data,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [7:0]        wr_data
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
